// ===== src/assert_macros.svh =====
// assertion macros shared by the mixer rtl
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GMO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GMO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GMO_ASSERT(lbl, prop, msg)
`define GMO_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== src/gmo_pkg.sv =====
// types and constants of the gain mixer
// no dependencies
package gmo_pkg;

  localparam int NUM_CH     = 4;
  localparam int MIN_CH     = 2;
  localparam int CH_IDX_W   = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int SAMPLE_W   = 24;
  localparam int GAIN_W     = 16;
  localparam int FRAC_SHIFT = 12;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int CONTRIB_W  = PROD_W - FRAC_SHIFT;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LATENCY    = 2 * NUM_CH + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_BASE     = 3'd1;

  localparam logic [CNT_W-1:0]           CNT_RESET  = 3'd4;
  localparam logic [GAIN_W-1:0]          GAIN_RESET = 16'd4096;
  localparam logic signed [SAMPLE_W-1:0] MIX_ONE    = 24'sd1048576;

  typedef struct packed {
    logic [NUM_CH-1:0]              en;
    logic [NUM_CH-1:0][GAIN_W-1:0] gain;
  } mix_cfg_t;

  typedef struct packed {
    logic                            valid;
    logic [NUM_CH-1:0][SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0]             sum;
    logic [NUM_CH-1:0]               peaks;
  } frame_t;

endpackage

// ===== src/gmo_cfg.sv =====
// configuration registers: channel count and per-channel gains
// depends on gmo_pkg
module gmo_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gmo_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gmo_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output gmo_pkg::mix_cfg_t                  cfg_o
);
  import gmo_pkg::*;

  logic [CNT_W-1:0]              count_q;
  logic [NUM_CH-1:0][GAIN_W-1:0] gains_q;
  logic [CNT_W-1:0]              count_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_RESET;
      for (int c = 0; c < NUM_CH; c++) begin
        gains_q[c] <= GAIN_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_CHANNEL_COUNT) begin
        count_q <= cfg_wdata_i[CNT_W-1:0];
      end
      for (int c = 0; c < NUM_CH; c++) begin
        if (cfg_idx_i == CFG_IDX_W'(int'(CFG_GAIN_BASE) + c)) begin
          gains_q[c] <= cfg_wdata_i[GAIN_W-1:0];
        end
      end
    end
  end

  // clamp to the supported channel range
  always_comb begin
    count_eff = count_q;
    if (count_q < CNT_W'(MIN_CH)) begin
      count_eff = CNT_W'(MIN_CH);
    end else if (count_q > CNT_W'(NUM_CH)) begin
      count_eff = CNT_W'(NUM_CH);
    end
  end

  always_comb begin
    cfg_o.gain = gains_q;
    for (int c = 0; c < NUM_CH; c++) begin
      cfg_o.en[c] = (int'(count_eff) > c) && (gains_q[c] != '0);
    end
  end

endmodule

// ===== src/gmo_cell.sv =====
// one channel cell: multiply and shift, then range-checked accumulate
// depends on gmo_pkg and assert_macros.svh
`include "assert_macros.svh"

module gmo_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [gmo_pkg::CH_IDX_W-1:0]   idx_i,
  input  logic                           en_i,
  input  logic [gmo_pkg::GAIN_W-1:0]     gain_i,
  input  gmo_pkg::frame_t                frame_i,
  output gmo_pkg::frame_t                frame_o
);
  import gmo_pkg::*;

  logic signed [PROD_W-1:0]    prod;
  logic signed [CONTRIB_W-1:0] contrib_wide;
  logic [CONTRIB_W-SAMPLE_W:0] top_bits;
  logic                        take_d;

  frame_t                      frame_a_q;
  logic [SAMPLE_W-1:0]         contrib_a_q;
  logic                        take_a_q;

  logic [SAMPLE_W:0]           mixed;
  logic                        accept_ok;
  frame_t                      frame_b_d;
  frame_t                      frame_b_q;

  // multiply stage
  always_comb begin
    prod         = $signed(frame_i.sample[idx_i]) * $signed(gain_i);
    contrib_wide = CONTRIB_W'(prod >>> FRAC_SHIFT);
    top_bits     = contrib_wide[CONTRIB_W-1:SAMPLE_W-1];
    take_d       = en_i && ((&top_bits) || (~|top_bits));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_a_q <= '0;
      take_a_q  <= 1'b0;
    end else begin
      frame_a_q <= frame_i;
      take_a_q  <= take_d;
    end
  end

  always_ff @(posedge clk_i) begin
    contrib_a_q <= contrib_wide[SAMPLE_W-1:0];
  end

  // accumulate stage
  always_comb begin
    mixed     = {frame_a_q.sum[SAMPLE_W-1], frame_a_q.sum}
              + {contrib_a_q[SAMPLE_W-1], contrib_a_q};
    accept_ok = take_a_q && (mixed[SAMPLE_W] == mixed[SAMPLE_W-1]);
    frame_b_d = frame_a_q;
    if (accept_ok) begin
      frame_b_d.sum        = mixed[SAMPLE_W-1:0];
      frame_b_d.peaks[idx_i] = $signed(contrib_a_q) > MIX_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_b_q <= '0;
    end else begin
      frame_b_q <= frame_b_d;
    end
  end

  assign frame_o = frame_b_q;

  `GMO_ASSERT(a_cell_flow, frame_i.valid |-> ##2 frame_o.valid, "cell lost a request")
  `GMO_ASSERT(a_cell_keep, frame_a_q.valid && !accept_ok |=> frame_o.sum == $past(frame_a_q.sum), "rejected channel changed the sum")
  `GMO_ASSERT(a_cell_peak, !accept_ok |=> frame_o.peaks == $past(frame_a_q.peaks), "peak on skipped channel")

endmodule

// ===== src/gain_mixer_with_overflow_reject.sv =====
// gain mixer top level: config registers, chain of channel cells, output register
// each request passes the multiply and accumulate registers of every channel cell, then the output register
// throughput: one request per cycle, busy_o is always low; results cannot be stalled
// reset: channel count 4, all gains unity, pipeline emptied
// depends on gmo_pkg, gmo_cfg, gmo_cell and assert_macros.svh
`include "assert_macros.svh"

module gain_mixer_with_overflow_reject (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gmo_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gmo_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [gmo_pkg::SAMPLE_W-1:0] sample_ch0_i,
  input  logic signed [gmo_pkg::SAMPLE_W-1:0] sample_ch1_i,
  input  logic signed [gmo_pkg::SAMPLE_W-1:0] sample_ch2_i,
  input  logic signed [gmo_pkg::SAMPLE_W-1:0] sample_ch3_i,
  output logic                               valid_o,
  output logic signed [gmo_pkg::SAMPLE_W-1:0] mix_out_o,
  output logic                               mix_peak_o,
  output logic [gmo_pkg::NUM_CH-1:0]         channel_peaks_o
);
  import gmo_pkg::*;

  mix_cfg_t            cfg;
  frame_t              chain [NUM_CH+1];
  logic                valid_q;
  logic [SAMPLE_W-1:0] mix_q;
  logic                peak_q;
  logic [NUM_CH-1:0]   peaks_q;

  assign busy_o = 1'b0;

  gmo_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  always_comb begin
    chain[0].valid     = start_i && !busy_o;
    chain[0].sample[0] = sample_ch0_i;
    chain[0].sample[1] = sample_ch1_i;
    chain[0].sample[2] = sample_ch2_i;
    chain[0].sample[3] = sample_ch3_i;
    chain[0].sum       = '0;
    chain[0].peaks     = '0;
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_cell
    gmo_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (CH_IDX_W'(c)),
      .en_i    (cfg.en[c]),
      .gain_i  (cfg.gain[c]),
      .frame_i (chain[c]),
      .frame_o (chain[c+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= chain[NUM_CH].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    mix_q   <= chain[NUM_CH].sum;
    peak_q  <= $signed(chain[NUM_CH].sum) > MIX_ONE;
    peaks_q <= chain[NUM_CH].peaks;
  end

  assign valid_o         = valid_q;
  assign mix_out_o       = mix_q;
  assign mix_peak_o      = peak_q;
  assign channel_peaks_o = peaks_q;

  `GMO_ASSERT(a_req_done, start_i && !busy_o |-> ##LATENCY valid_o, "request produced no result")
  `GMO_ASSERT(a_no_ghost, valid_o |-> $past(start_i, LATENCY), "result without request")
  `GMO_ASSERT_RST(a_rst_quiet, !rst_ni |-> !valid_o, "strobe during reset")

endmodule

// ===== tb/gain_mixer_with_overflow_reject_test.sv =====
// testbench for gain_mixer_with_overflow_reject: directed and random frames under changing gains
// results are checked field by field against a predictor kept in this file
// depends on gmo_pkg and the gain_mixer_with_overflow_reject rtl
module gain_mixer_with_overflow_reject_test;
  import gmo_pkg::*;

  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] sample_set_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mix;
    logic                peak;
    logic [NUM_CH-1:0]   peaks;
  } mix_result_t;

  localparam longint S24_MAX    = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint S24_MIN    = -(longint'(1) << (SAMPLE_W - 1));
  localparam int     NUM_PHASES = 12;
  localparam int     PHASE_LEN  = 125;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i;
  logic                       start_i;
  logic                       busy_o;
  logic signed [SAMPLE_W-1:0] sample_ch0_i;
  logic signed [SAMPLE_W-1:0] sample_ch1_i;
  logic signed [SAMPLE_W-1:0] sample_ch2_i;
  logic signed [SAMPLE_W-1:0] sample_ch3_i;
  logic                       valid_o;
  logic signed [SAMPLE_W-1:0] mix_out_o;
  logic                       mix_peak_o;
  logic [NUM_CH-1:0]          channel_peaks_o;

  logic [CNT_W-1:0]           model_count;
  logic signed [GAIN_W-1:0]   model_gain [NUM_CH];
  mix_result_t                pending_mix [$];
  int                         errors;
  int                         frames_sent;
  int                         results_checked;
  int                         settings_used;
  int                         burst_left;

  gain_mixer_with_overflow_reject u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .sample_ch0_i    (sample_ch0_i),
    .sample_ch1_i    (sample_ch1_i),
    .sample_ch2_i    (sample_ch2_i),
    .sample_ch3_i    (sample_ch3_i),
    .valid_o         (valid_o),
    .mix_out_o       (mix_out_o),
    .mix_peak_o      (mix_peak_o),
    .channel_peaks_o (channel_peaks_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("** gain_mixer_with_overflow_reject: FAILED **");
    $finish;
  end

  function automatic mix_result_t predict_mix(input sample_set_t smp);
    mix_result_t r;
    longint      acc;
    longint      contrib;
    longint      total;
    int          n;
    r   = '0;
    acc = 0;
    n   = int'(model_count);
    if (n < MIN_CH) n = MIN_CH;
    if (n > NUM_CH) n = NUM_CH;
    for (int c = 0; c < n; c++) begin
      if (model_gain[c] != 0) begin
        contrib = (longint'($signed(smp[c])) * longint'(model_gain[c])) >>> FRAC_SHIFT;
        total   = acc + contrib;
        if (contrib <= S24_MAX && contrib >= S24_MIN && total <= S24_MAX && total >= S24_MIN) begin
          acc = total;
          if (contrib > longint'(MIX_ONE)) r.peaks[c] = 1'b1;
        end
      end
    end
    r.mix  = acc[SAMPLE_W-1:0];
    r.peak = (acc > longint'(MIX_ONE));
    return r;
  endfunction

  task automatic report_error(input string msg);
    if (errors < 50) $display("[%0t] error: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    mix_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_mix.size() == 0) begin
        report_error("result with no request waiting");
      end else begin
        want = pending_mix.pop_front();
        results_checked++;
        if (mix_out_o !== want.mix)
          report_error($sformatf("mix_out: got %0d, expected %0d", mix_out_o, $signed(want.mix)));
        if (mix_peak_o !== want.peak)
          report_error($sformatf("mix_peak: got %b, expected %b", mix_peak_o, want.peak));
        if (channel_peaks_o !== want.peaks)
          report_error($sformatf("channel_peaks: got %b, expected %b",
                                 channel_peaks_o, want.peaks));
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CHANNEL_COUNT) begin
      model_count = data[CNT_W-1:0];
    end else if (idx >= CFG_GAIN_BASE && idx < CFG_GAIN_BASE + NUM_CH) begin
      model_gain[idx - CFG_GAIN_BASE] = data;
    end
    @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] cnt);
    logic [CFG_DATA_W-1:0] data;
    data            = CFG_DATA_W'($urandom());
    data[CNT_W-1:0] = cnt;
    write_reg(CFG_CHANNEL_COUNT, data);
  endtask

  task automatic write_gains(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                             input logic [GAIN_W-1:0] g2, input logic [GAIN_W-1:0] g3);
    write_reg(CFG_GAIN_BASE, g0);
    write_reg(CFG_GAIN_BASE + 3'd1, g1);
    write_reg(CFG_GAIN_BASE + 3'd2, g2);
    write_reg(CFG_GAIN_BASE + 3'd3, g3);
    settings_used++;
  endtask

  task automatic send_frame(input sample_set_t smp);
    int gap;
    start_i      <= 1'b1;
    sample_ch0_i <= smp[0];
    sample_ch1_i <= smp[1];
    sample_ch2_i <= smp[2];
    sample_ch3_i <= smp[3];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_mix = {pending_mix, predict_mix(smp)};
    frames_sent++;
    if (burst_left == 0) begin
      gap     = $urandom_range(1, 12);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // lower start, wait for every result, then let the pipeline settle
  task automatic drain;
    if (start_i) start_i <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int v;
    case ($urandom_range(0, 9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return MIX_ONE + SAMPLE_W'($urandom_range(0, 1));
      3, 4: begin
        v = int'($urandom_range(0, 2 * 1048576 + 64)) - 1048576 - 32;
        return v[SAMPLE_W-1:0];
      end
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'h7fff;
      2: return 16'h8000;
      3, 4: begin
        v = 4096 + int'($urandom_range(0, 512)) - 256;
        return v[GAIN_W-1:0];
      end
      5: begin
        v = -4096 - int'($urandom_range(0, 512)) + 256;
        return v[GAIN_W-1:0];
      end
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  // reset gains, sample extremes, sum overflow rejection
  task automatic test_reset_values;
    send_frame({4{24'h7fffff}});
    send_frame({4{24'h800000}});
    send_frame({4{24'h000000}});
    send_frame({24'hffffff, 24'h100001, 24'h100000, 24'h100001});
    send_frame({24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa});
    send_frame({24'h700000, 24'h700000, 24'h900000, 24'h900000});
    drain();
  endtask

  // count values below, inside and above the legal range; those outside it are clamped
  task automatic test_channel_count;
    logic [CNT_W-1:0] counts [5] = '{3'd0, 3'd1, 3'd3, 3'd5, 3'd7};
    foreach (counts[i]) begin
      write_count(counts[i]);
      send_frame({4{24'h180000}});
      drain();
    end
  endtask

  // zero gain skip, gain extremes, contribution overflow, unused register indexes
  task automatic test_gain_extremes;
    write_count(3'd4);
    write_gains(16'h0000, 16'h7fff, 16'h8000, 16'h0001);
    send_frame({4{24'h7fffff}});
    send_frame({4{24'h800000}});
    send_frame({24'h123456, 24'h000100, 24'hffff00, 24'h000020});
    drain();
    write_gains(16'hffff, 16'hf000, 16'h1000, 16'h0000);
    send_frame({24'h200000, 24'hf00000, 24'h300000, 24'h7fffff});
    send_frame({24'h800000, 24'h7fffff, 24'h123456, 24'h654321});
    drain();
    write_reg(3'd5, CFG_DATA_W'($urandom()));
    write_reg(3'd6, CFG_DATA_W'($urandom()));
    write_reg(3'd7, CFG_DATA_W'($urandom()));
    send_frame({24'h200000, 24'hf00000, 24'h300000, 24'h7fffff});
    drain();
  endtask

  task automatic test_random_mix;
    sample_set_t smp;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_count(3'd7);
          write_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        end
        1: begin
          write_count(3'd0);
          write_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        end
        2: begin
          write_count(3'd2);
          write_gains(GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET);
        end
        default: begin
          write_count(CNT_W'($urandom_range(0, 7)));
          write_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
        end
      endcase
      for (int k = 0; k < PHASE_LEN; k++) begin
        for (int c = 0; c < NUM_CH; c++) smp[c] = rand_sample();
        send_frame(smp);
      end
      drain();
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= '0;
    cfg_wdata_i  <= '0;
    start_i      <= 1'b0;
    sample_ch0_i <= '0;
    sample_ch1_i <= '0;
    sample_ch2_i <= '0;
    sample_ch3_i <= '0;
    errors          = 0;
    frames_sent     = 0;
    results_checked = 0;
    settings_used   = 1;
    burst_left      = $urandom_range(0, 12);
    model_count     = CNT_RESET;
    foreach (model_gain[c]) model_gain[c] = GAIN_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_channel_count();
    test_gain_extremes();
    test_random_mix();

    if (pending_mix.size() != 0)
      report_error($sformatf("%0d requests never produced a result", pending_mix.size()));
    $display("run covered %0d requests and %0d checked results", frames_sent, results_checked);
    $display("over %0d gain settings and channel counts inside and outside the legal range",
             settings_used);
    if (errors == 0) begin
      $display("** gain_mixer_with_overflow_reject: PASSED **");
    end else begin
      $display("** gain_mixer_with_overflow_reject: FAILED **");
    end
    $finish;
  end

endmodule
